/* sv/lpht_pkg.sv */
package lpht_pkg;

  localparam int unsigned MODE_W   = 1;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  // Number of shift/add and shift/xor rounds in the key mix
  localparam int unsigned MIX_STEPS = 8;

  typedef struct packed {
    logic               used;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } lpht_slot_t;

  // One round of the 32-bit integer avalanche mix, selected by round index
  function automatic logic [KEY_W-1:0] lpht_mix_step(input logic [KEY_W-1:0] k,
                                                     input logic [2:0]       step);
    logic [KEY_W-1:0] r;
    case (step)
      3'd0:    r = k + (k << 12);
      3'd1:    r = k ^ (k >> 22);
      3'd2:    r = k + (k << 4);
      3'd3:    r = k ^ (k >> 9);
      3'd4:    r = k + (k << 10);
      3'd5:    r = k ^ (k >> 2);
      3'd6:    r = k + (k << 7);
      default: r = k ^ (k >> 12);
    endcase
    return r;
  endfunction

endpackage

/* sv/lpht_req_if.sv */
interface lpht_req_if import lpht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [KEY_W-1:0]   key;
  logic [VALUE_W-1:0] value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

/* sv/lpht_rsp_if.sv */
interface lpht_rsp_if import lpht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VALUE_W-1:0]  found_value;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, found_value, entry_count, input ready);
  modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

/* sv/linear_probe_hash_table_unit.sv */
// Linear-probing hash table of TABLE_DEPTH slots keyed by a 32-bit key.
// Request channel req_i carries mode (insert or lookup), key and value; the
// response channel rsp_o returns status, found_value and entry_count, one
// response per request, in order.
// An item is taken only while the unit is idle. The home slot is found in one
// shared unit by an 8-round shift/add/xor mix and a remainder by the table
// depth through a reciprocal multiply, a multiply-subtract and one correcting
// subtract; each probe then reads the slot memory, then compares. Up to
// TABLE_DEPTH slots are probed per item, and a new request is taken only after
// the response of the last one has gone to the output register.
// An insert on a full table skips the hash and the probes and goes straight to
// the response.
// After reset the unit sweeps the slot memory to clear the in-use marks, one
// slot a cycle over all TABLE_DEPTH slots, and holds req_i.ready low meanwhile.
// A response is held in an output register until it is taken; the unit takes
// and works on the next request meanwhile, then holds its result and keeps
// req_i.ready low until the register is free.
module linear_probe_hash_table_unit import lpht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lpht_req_if.sink       req_i,
  lpht_rsp_if.source     rsp_o
);

  localparam int unsigned SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(TABLE_DEPTH + 1);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TABLE_DEPTH - 1);
  localparam logic [CntW-1:0]  DepthCnt = CntW'(TABLE_DEPTH);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic [CntW-1:0]     probe_q, probe_d;
  logic [CntW-1:0]     occ_q, occ_d;
  logic [MODE_W-1:0]   mode_q, mode_d;
  logic [KEY_W-1:0]    key_q, key_d;
  logic [VALUE_W-1:0]  value_q, value_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [VALUE_W-1:0]  found_q, found_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0] rsp_status_q, rsp_status_d;
  logic [VALUE_W-1:0]  rsp_found_q, rsp_found_d;
  logic [COUNT_W-1:0]  rsp_count_q, rsp_count_d;

  logic                hash_start;
  logic                hash_done;
  logic [SlotW-1:0]    hash_slot;
  logic                mem_we;
  lpht_slot_t          mem_wdata;
  lpht_slot_t          mem_rdata;
  logic [CntW-1:0]     probe_inc;
  logic [CntW+COUNT_W-1:0] occ_wide;

  lpht_hash #(.TABLE_DEPTH(TABLE_DEPTH)) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (req_i.key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  lpht_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (slot_q),
    .wdata_i (mem_wdata),
    .raddr_i (slot_q),
    .rdata_o (mem_rdata)
  );

  assign probe_inc = probe_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    probe_d      = probe_q;
    occ_d        = occ_q;
    mode_d       = mode_q;
    key_d        = key_q;
    value_d      = value_q;
    status_d     = status_q;
    found_d      = found_q;
    rsp_valid_d  = rsp_valid_q;
    rsp_status_d = rsp_status_q;
    rsp_found_d  = rsp_found_q;
    rsp_count_d  = rsp_count_q;
    hash_start   = 1'b0;
    mem_we       = 1'b0;
    mem_wdata    = '{used: 1'b1, key: key_q, value: value_q};
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '{used: 1'b0, key: '0, value: '0};
        slot_d    = slot_q + 1'b1;
        if (slot_q == LastSlot) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          mode_d  = req_i.mode;
          key_d   = req_i.key;
          value_d = req_i.value;
          found_d = '0;
          if (req_i.mode == MODE_INSERT && occ_q == DepthCnt) begin
            status_d = ST_FULL;
            state_d  = S_RESP;
          end else begin
            hash_start = 1'b1;
            state_d    = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          slot_d  = hash_slot;
          probe_d = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!mem_rdata.used) begin
          if (mode_q == MODE_INSERT) begin
            mem_we   = 1'b1;
            occ_d    = occ_q + 1'b1;
            status_d = ST_OK;
          end else begin
            status_d = ST_MISSING;
          end
          state_d = S_RESP;
        end else if (mem_rdata.key == key_q) begin
          if (mode_q == MODE_INSERT) begin
            mem_we = 1'b1;
          end else begin
            found_d = mem_rdata.value;
          end
          status_d = ST_OK;
          state_d  = S_RESP;
        end else if (probe_inc == DepthCnt) begin
          // whole table probed without a usable slot
          status_d = (mode_q == MODE_INSERT) ? ST_FULL : ST_MISSING;
          state_d  = S_RESP;
        end else begin
          probe_d = probe_inc;
          slot_d  = (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_RESP: begin
        // hand the item over once the output register is free
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_found_d  = found_q;
          rsp_count_d  = occ_wide[COUNT_W-1:0];
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      slot_q      <= '0;
      probe_q     <= '0;
      occ_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      probe_q     <= probe_d;
      occ_q       <= occ_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    key_q        <= key_d;
    value_q      <= value_d;
    status_q     <= status_d;
    found_q      <= found_d;
    rsp_status_q <= rsp_status_d;
    rsp_found_q  <= rsp_found_d;
    rsp_count_q  <= rsp_count_d;
  end

  assign occ_wide = (CntW+COUNT_W)'(occ_q);

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_value = rsp_found_q;
  assign rsp_o.entry_count = rsp_count_q;

endmodule

/* sv/lpht_hash.sv */
module lpht_hash import lpht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [SlotW-1:0] slot_o
);

  // Scaled reciprocal of the depth; the quotient it gives is exact or one short
  localparam int unsigned      RecipShift = KEY_W - 1 + SlotW;
  localparam logic [KEY_W-1:0] RecipC     = KEY_W'((64'd1 << RecipShift) / 64'(TABLE_DEPTH));
  localparam logic [KEY_W-1:0] DepthK     = KEY_W'(TABLE_DEPTH);
  localparam logic [SlotW:0]   DepthC     = (SlotW+1)'(TABLE_DEPTH);
  localparam logic [2:0]       LastStep   = 3'(MIX_STEPS - 1);

  localparam logic [1:0] PH_MIX = 2'd0;
  localparam logic [1:0] PH_MUL = 2'd1;
  localparam logic [1:0] PH_SUB = 2'd2;
  localparam logic [1:0] PH_FIX = 2'd3;

  logic               busy_q, busy_d;
  logic [1:0]         phase_q, phase_d;
  logic               done_q, done_d;
  logic [2:0]         step_q, step_d;
  logic [KEY_W-1:0]   k_q, k_d;
  logic [KEY_W-1:0]   q_q, q_d;
  logic [SlotW:0]     rem_q, rem_d;
  logic [SlotW-1:0]   r_q, r_d;
  logic [2*KEY_W-1:0] prod;
  logic [KEY_W-1:0]   qd;
  logic [KEY_W-1:0]   diff;
  logic [SlotW:0]     rem_sub;

  assign prod    = (2*KEY_W)'(k_q) * (2*KEY_W)'(RecipC);
  assign qd      = q_q * DepthK;
  assign diff    = k_q - qd;
  assign rem_sub = rem_q - DepthC;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    step_d  = step_q;
    k_d     = k_q;
    q_d     = q_q;
    rem_d   = rem_q;
    r_d     = r_q;
    if (start_i) begin
      busy_d  = 1'b1;
      phase_d = PH_MIX;
      step_d  = '0;
      k_d     = key_i;
    end else if (busy_q) begin
      case (phase_q)
        PH_MIX: begin
          k_d    = lpht_mix_step(k_q, step_q);
          step_d = step_q + 3'd1;
          if (step_q == LastStep) begin
            phase_d = PH_MUL;
          end
        end
        PH_MUL: begin
          q_d     = KEY_W'(prod >> RecipShift);
          phase_d = PH_SUB;
        end
        PH_SUB: begin
          // remainder is below twice the depth here
          rem_d   = diff[SlotW:0];
          phase_d = PH_FIX;
        end
        default: begin
          r_d    = (rem_q >= DepthC) ? rem_sub[SlotW-1:0] : rem_q[SlotW-1:0];
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= PH_MIX;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    q_q   <= q_d;
    rem_q <= rem_d;
    r_q   <= r_d;
  end

  assign done_o = done_q;
  assign slot_o = r_q;

endmodule

/* sv/lpht_mem.sv */
module lpht_mem import lpht_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  localparam int unsigned SlotW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] waddr_i,
  input  lpht_slot_t       wdata_i,
  input  logic [SlotW-1:0] raddr_i,
  output lpht_slot_t       rdata_o
);

  lpht_slot_t mem_q [TABLE_DEPTH];
  lpht_slot_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
